[rtl/assert_macros.svh]
// Assertion macros for the RTL; the detector top level includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_CLKRST(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");
`define ASSERT_CLK(label, clk, prop) \
  label: assert property (@(posedge clk) (prop)) else $error("assertion failed");
`else
`define ASSERT_CLKRST(label, clk, rst_n, prop)
`define ASSERT_CLK(label, clk, prop)
`endif
`endif

[rtl/bmcd_pkg.sv]
// Types and constants of the button click detector.
package bmcd_pkg;

  localparam int unsigned IdxW  = 4;
  localparam int unsigned MaxBtn = 16;
  localparam int unsigned CntW  = 10;
  localparam int unsigned HoldW = 11;
  localparam int unsigned ClkW  = 2;
  localparam int unsigned CfgIdxW = 3;

  localparam logic            ActiveLowRst     = 1'b0;
  localparam logic [CntW-1:0] HoldTimeRst      = 10'd100;
  localparam logic [CntW-1:0] ClickWindowRst   = 10'd30;
  localparam logic [ClkW-1:0] MaxClicksRst     = 2'd3;
  localparam logic [CntW-1:0] RepeatDividerRst = 10'd10;

  typedef enum logic [2:0] {
    EV_NONE        = 3'd0,
    EV_SINGLE      = 3'd1,
    EV_DOUBLE      = 3'd2,
    EV_TRIPLE      = 3'd3,
    EV_HOLD_START  = 3'd4,
    EV_HOLD_REPEAT = 3'd5
  } event_code_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_ACTIVE_LOW     = 3'd0,
    CFG_HOLD_TIME      = 3'd1,
    CFG_CLICK_WINDOW   = 3'd2,
    CFG_MAX_CLICKS     = 3'd3,
    CFG_REPEAT_DIVIDER = 3'd4
  } cfg_reg_e;

  typedef enum logic {
    SWEEP_IDLE,
    SWEEP_RUN
  } sweep_state_e;

endpackage

[rtl/button_multi_click_detector.sv]
// Top level of the multi-click and long-press detector.
//
// Sample channel: one tick sample per request (button_index_i, pin_level_i).
// Event channel: exactly one event per sample (event_button_o, event_code_o),
// event_code 0 when nothing happened on that tick.
// Config channel: cfg_index_i selects active_low, hold_time, click_window,
// max_clicks or repeat_divider; write only while no sample is in flight.
// One sample is taken per cycle while the receiver keeps up and no pass runs;
// a sample goes through the sample stage into the event register, which presents its event.
// The per-button counters sit in flip-flops and are read, updated and written
// back in the same cycle, so samples of the same button may follow back to back.
// When the receiver stalls, the event register and the sample register hold
// and sample_ready_o drops; nothing is lost.
// Reset clears all per-button state and loads the default configuration.
// A write to repeat_divider starts a pass that recomputes every button's
// repeat phase modulo the new divider into a reduced copy, bit by bit from the
// top bit down and button after button; during the pass no sample and
// no config write is taken.
module button_multi_click_detector
  import bmcd_pkg::*;
#(
  parameter int unsigned NUM_BUTTONS = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CntW-1:0]     cfg_data_i,
  input  logic                sample_valid_i,
  output logic                sample_ready_o,
  input  logic [IdxW-1:0]     button_index_i,
  input  logic                pin_level_i,
  output logic                event_valid_o,
  input  logic                event_ready_i,
  output logic [IdxW-1:0]     event_button_o,
  output logic [2:0]          event_code_o
);

`include "assert_macros.svh"

  localparam int unsigned NbEff = (NUM_BUTTONS < MaxBtn) ? NUM_BUTTONS : MaxBtn;
  localparam int unsigned AddrW = (NbEff > 1) ? $clog2(NbEff) : 1;
  localparam int unsigned BitW  = $clog2(CntW);

  // configuration
  logic            active_low_q;
  logic [CntW-1:0] hold_time_q, click_window_q, repeat_divider_q;
  logic [ClkW-1:0] max_clicks_q;
  logic            cfg_fire;

  assign cfg_fire = cfg_valid_i && cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_low_q     <= ActiveLowRst;
      hold_time_q      <= HoldTimeRst;
      click_window_q   <= ClickWindowRst;
      max_clicks_q     <= MaxClicksRst;
      repeat_divider_q <= RepeatDividerRst;
    end else if (cfg_fire) begin
      unique case (cfg_index_i)
        CFG_ACTIVE_LOW:     active_low_q     <= cfg_data_i[0];
        CFG_HOLD_TIME:      hold_time_q      <= cfg_data_i;
        CFG_CLICK_WINDOW:   click_window_q   <= cfg_data_i;
        CFG_MAX_CLICKS:     max_clicks_q     <= cfg_data_i[ClkW-1:0];
        CFG_REPEAT_DIVIDER: repeat_divider_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic [CntW-1:0] div_eff;
  assign div_eff = (repeat_divider_q == '0) ? CntW'(1) : repeat_divider_q;

  // sweep control
  sweep_state_e     sweep_state_q, sweep_state_d;
  logic [AddrW-1:0] sweep_entry_q, sweep_entry_d;
  logic [BitW-1:0]  sweep_bit_q, sweep_bit_d;
  logic [CntW-1:0]  sweep_rem_q, sweep_rem_d;
  logic             sweep_wr;
  logic [CntW:0]    sweep_shift;
  logic [CntW-1:0]  sweep_next_rem;

  // per-button state
  logic [HoldW-1:0] hold_q  [NbEff];
  logic [ClkW-1:0]  click_q [NbEff];
  logic [CntW-1:0]  win_q   [NbEff];
  logic [CntW-1:0]  phase_q [NbEff];
  logic [CntW-1:0]  red_q   [NbEff];

  // sample stage and event register
  logic            s1_valid_q;
  logic [IdxW-1:0] s1_idx_q;
  logic            s1_pin_q;
  logic            s1_fire;
  logic            out_valid_q;
  logic [IdxW-1:0] out_button_q;
  event_code_e     out_code_q;

  logic [AddrW-1:0] rd_addr;
  logic             in_range;
  logic [HoldW-1:0] h_rd, h_inc, h_new;
  logic [ClkW-1:0]  c_rd, c_new;
  logic [CntW-1:0]  w_rd, w_new, p_rd, p_inc, p_new, r_rd, r_new;
  logic             pressed;
  event_code_e      ev;

  assign rd_addr  = (sweep_state_q == SWEEP_RUN) ? sweep_entry_q : s1_idx_q[AddrW-1:0];
  assign in_range = ({1'b0, s1_idx_q} < (IdxW+1)'(NbEff));
  assign h_rd     = hold_q[rd_addr];
  assign c_rd     = click_q[rd_addr];
  assign w_rd     = win_q[rd_addr];
  assign p_rd     = phase_q[rd_addr];
  assign r_rd     = red_q[rd_addr];

  assign sweep_shift    = {sweep_rem_q, p_rd[sweep_bit_q]};
  assign sweep_next_rem = (sweep_shift >= {1'b0, div_eff}) ?
                          CntW'(sweep_shift - {1'b0, div_eff}) : sweep_shift[CntW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sweep_state_q <= SWEEP_IDLE;
      sweep_entry_q <= '0;
      sweep_bit_q   <= '0;
      sweep_rem_q   <= '0;
    end else begin
      sweep_state_q <= sweep_state_d;
      sweep_entry_q <= sweep_entry_d;
      sweep_bit_q   <= sweep_bit_d;
      sweep_rem_q   <= sweep_rem_d;
    end
  end

  always_comb begin
    sweep_state_d = sweep_state_q;
    sweep_entry_d = sweep_entry_q;
    sweep_bit_d   = sweep_bit_q;
    sweep_rem_d   = sweep_rem_q;
    sweep_wr      = 1'b0;
    unique case (sweep_state_q)
      SWEEP_IDLE: begin
        if (cfg_fire && (cfg_index_i == CFG_REPEAT_DIVIDER)) begin
          sweep_state_d = SWEEP_RUN;
          sweep_entry_d = '0;
          sweep_bit_d   = BitW'(CntW-1);
          sweep_rem_d   = '0;
        end
      end
      SWEEP_RUN: begin
        if (sweep_bit_q == '0) begin
          sweep_wr      = 1'b1;
          sweep_rem_d   = '0;
          sweep_bit_d   = BitW'(CntW-1);
          sweep_entry_d = AddrW'(sweep_entry_q + 1'b1);
          if (sweep_entry_q == AddrW'(NbEff-1)) begin
            sweep_state_d = SWEEP_IDLE;
          end
        end else begin
          sweep_rem_d = sweep_next_rem;
          sweep_bit_d = BitW'(sweep_bit_q - 1'b1);
        end
      end
      default: sweep_state_d = SWEEP_IDLE;
    endcase
  end

  // per-sample update
  assign pressed = s1_pin_q ^ active_low_q;
  assign h_inc   = HoldW'(h_rd + 1'b1);
  assign p_inc   = CntW'(r_rd + 1'b1);

  always_comb begin
    h_new = h_rd;
    c_new = c_rd;
    w_new = w_rd;
    p_new = p_rd;
    r_new = r_rd;
    ev    = EV_NONE;
    if (pressed) begin
      if ((h_rd == '0) && (c_rd < max_clicks_q)) begin
        c_new = ClkW'(c_rd + 1'b1);
        w_new = click_window_q;
      end
      if (h_rd <= {1'b0, hold_time_q}) begin
        h_new = h_inc;
        if (h_inc == {1'b0, hold_time_q}) begin
          c_new = '0;
          w_new = '0;
          ev    = EV_HOLD_START;
        end
      end else begin
        p_new = (p_inc == div_eff) ? '0 : p_inc;
        r_new = p_new;
        if (p_inc == div_eff) begin
          ev = EV_HOLD_REPEAT;
        end
      end
    end else begin
      if ((h_rd < {1'b0, hold_time_q}) && (w_rd != '0)) begin
        if (w_rd == CntW'(1)) begin
          ev    = event_code_e'({1'b0, c_rd});
          c_new = '0;
          w_new = '0;
        end else begin
          w_new = CntW'(w_rd - 1'b1);
        end
      end
      h_new = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NbEff; i++) begin
        hold_q[i]  <= '0;
        click_q[i] <= '0;
        win_q[i]   <= '0;
        phase_q[i] <= '0;
        red_q[i]   <= '0;
      end
    end else if (sweep_wr) begin
      red_q[rd_addr] <= sweep_next_rem;
    end else if (s1_fire && in_range) begin
      hold_q[rd_addr]  <= h_new;
      click_q[rd_addr] <= c_new;
      win_q[rd_addr]   <= w_new;
      phase_q[rd_addr] <= p_new;
      red_q[rd_addr]   <= r_new;
    end
  end

  // handshake
  assign s1_fire        = s1_valid_q && (!out_valid_q || event_ready_i);
  assign sample_ready_o = (sweep_state_q == SWEEP_IDLE) && (!s1_valid_q || s1_fire);
  assign cfg_ready_o    = (sweep_state_q == SWEEP_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (sample_ready_o) begin
        s1_valid_q <= sample_valid_i;
      end else if (s1_fire) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_fire) begin
        out_valid_q <= 1'b1;
      end else if (event_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (sample_valid_i && sample_ready_o) begin
      s1_idx_q <= button_index_i;
      s1_pin_q <= pin_level_i;
    end
    if (s1_fire) begin
      out_button_q <= s1_idx_q;
      out_code_q   <= in_range ? ev : EV_NONE;
    end
  end

  assign event_valid_o  = out_valid_q;
  assign event_button_o = out_button_q;
  assign event_code_o   = out_code_q;

  `ASSERT_CLKRST(a_accept_loads_stage, clk_i, rst_ni,
                 (sample_valid_i && sample_ready_o) |=> s1_valid_q)
  `ASSERT_CLKRST(a_divider_write_sweeps, clk_i, rst_ni,
                 (cfg_fire && (cfg_index_i == CFG_REPEAT_DIVIDER)) |=> !sample_ready_o)
  `ASSERT_CLKRST(a_phase_below_divider, clk_i, rst_ni,
                 ((sweep_state_q == SWEEP_IDLE) && s1_valid_q && in_range) |-> (r_rd < div_eff))

endmodule

[test/button_multi_click_detector_test.sv]
// Testbench for the multi-click / long-press detector: directed table, random presses, idling.
`timescale 1ns / 1ps

module button_multi_click_detector_test;
  import bmcd_pkg::*;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int LONG_HOLD_OFF  = 80;
  localparam int PHASE_SAMPLES  = 120;

  typedef enum logic {
    ROW_SAMPLE,
    ROW_CONFIG
  } row_kind_e;

  typedef struct packed {
    row_kind_e         kind;
    cfg_reg_e          reg_sel;
    logic [CntW-1:0]   cfg_value;
    logic [IdxW-1:0]   button;
    logic              pin;
    logic              typed;
    event_code_e       code;
  } press_row_t;

  typedef struct packed {
    logic [IdxW-1:0] button;
    event_code_e     code;
  } click_event_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_valid_i = 1'b0;
  logic               cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index_i = '0;
  logic [CntW-1:0]    cfg_data_i = '0;
  logic               sample_valid_i = 1'b0;
  logic               sample_ready_o;
  logic [IdxW-1:0]    button_index_i = '0;
  logic               pin_level_i = 1'b0;
  logic               event_valid_o;
  logic               event_ready_i = 1'b0;
  logic [IdxW-1:0]    event_button_o;
  logic [2:0]         event_code_o;

  // Detector state as the testbench tracks it.
  logic              cfg_active_low;
  logic [CntW-1:0]   cfg_hold_time;
  logic [CntW-1:0]   cfg_click_window;
  logic [ClkW-1:0]   cfg_max_clicks;
  logic [CntW-1:0]   cfg_repeat_div;
  logic [HoldW-1:0]  hold_cnt   [MaxBtn];
  logic [ClkW-1:0]   clicks     [MaxBtn];
  logic [CntW-1:0]   window_cnt [MaxBtn];
  logic [CntW-1:0]   rep_phase  [MaxBtn];

  click_event_t pending_events[$];
  press_row_t   directed_rows[$];

  int mismatch_cnt;
  int samples_sent;
  int events_seen;
  int multi_clicks_seen;
  int hold_starts_seen;
  int hold_repeats_seen;
  int stall_cycles;
  int send_idle_pct;
  int recv_stall_pct;
  int hold_off_asked;
  int hold_off_seen;
  int hold_off_left;

  button_multi_click_detector u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .sample_valid_i (sample_valid_i),
    .sample_ready_o (sample_ready_o),
    .button_index_i (button_index_i),
    .pin_level_i    (pin_level_i),
    .event_valid_o  (event_valid_o),
    .event_ready_i  (event_ready_i),
    .event_button_o (event_button_o),
    .event_code_o   (event_code_o)
  );

  always #10 clk_i = ~clk_i;

  function automatic void reset_detector_state();
    cfg_active_low   = ActiveLowRst;
    cfg_hold_time    = HoldTimeRst;
    cfg_click_window = ClickWindowRst;
    cfg_max_clicks   = MaxClicksRst;
    cfg_repeat_div   = RepeatDividerRst;
    for (int b = 0; b < MaxBtn; b++) begin
      hold_cnt[b]   = '0;
      clicks[b]     = '0;
      window_cnt[b] = '0;
      rep_phase[b]  = '0;
    end
  endfunction

  function automatic void apply_register(cfg_reg_e sel, logic [CntW-1:0] value);
    case (sel)
      CFG_ACTIVE_LOW:     cfg_active_low   = value[0];
      CFG_HOLD_TIME:      cfg_hold_time    = value;
      CFG_CLICK_WINDOW:   cfg_click_window = value;
      CFG_MAX_CLICKS:     cfg_max_clicks   = value[ClkW-1:0];
      CFG_REPEAT_DIVIDER: cfg_repeat_div   = value;
      default: ;
    endcase
  endfunction

  function automatic event_code_e predict_click_event(logic [IdxW-1:0] idx, logic pin);
    event_code_e ev;
    int          div;
    ev = EV_NONE;
    if (pin ^ cfg_active_low) begin
      if (hold_cnt[idx] == '0 && clicks[idx] < cfg_max_clicks) begin
        clicks[idx]     = clicks[idx] + 1'b1;
        window_cnt[idx] = cfg_click_window;
      end
      if (int'(hold_cnt[idx]) < int'(cfg_hold_time) + 1) begin
        hold_cnt[idx] = hold_cnt[idx] + 1'b1;
        if (int'(hold_cnt[idx]) == int'(cfg_hold_time)) begin
          clicks[idx]     = '0;
          window_cnt[idx] = '0;
          ev = EV_HOLD_START;
        end
      end else begin
        div = (cfg_repeat_div == '0) ? 1 : int'(cfg_repeat_div);
        rep_phase[idx] = CntW'((int'(rep_phase[idx]) + 1) % div);
        if (rep_phase[idx] == '0) ev = EV_HOLD_REPEAT;
      end
    end else begin
      if (int'(hold_cnt[idx]) < int'(cfg_hold_time) && window_cnt[idx] != '0) begin
        if (window_cnt[idx] == 1) begin
          ev = event_code_e'({1'b0, clicks[idx]});
          clicks[idx]     = '0;
          window_cnt[idx] = '0;
        end else begin
          window_cnt[idx] = window_cnt[idx] - 1'b1;
        end
      end
      hold_cnt[idx] = '0;
    end
    return ev;
  endfunction

  function automatic press_row_t sample_row(logic [IdxW-1:0] btn, logic pin, logic typed,
                                            event_code_e code);
    press_row_t r;
    r = '0;
    r.kind   = ROW_SAMPLE;
    r.button = btn;
    r.pin    = pin;
    r.typed  = typed;
    r.code   = code;
    return r;
  endfunction

  function automatic press_row_t config_row(cfg_reg_e sel, logic [CntW-1:0] value);
    press_row_t r;
    r = '0;
    r.kind      = ROW_CONFIG;
    r.reg_sel   = sel;
    r.cfg_value = value;
    return r;
  endfunction

  // Drive one request, wait for acceptance, then queue its event.
  task automatic send_sample(logic [IdxW-1:0] btn, logic pin, logic typed, event_code_e code);
    click_event_t ev;
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      sample_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    sample_valid_i <= 1'b1;
    button_index_i <= btn;
    pin_level_i    <= pin;
    do @(posedge clk_i); while (!sample_ready_o);
    ev.button = btn;
    ev.code   = predict_click_event(btn, pin);
    if (typed) ev.code = code;
    pending_events.push_back(ev);
    samples_sent++;
  endtask

  // Drain all events, then write one register.
  task automatic write_reg(cfg_reg_e sel, logic [CntW-1:0] value);
    @(negedge clk_i);
    sample_valid_i <= 1'b0;
    while (pending_events.size() != 0) @(posedge clk_i);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= sel;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    apply_register(sel, value);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic run_phase(logic al, int ht, int cw, int mc, int rd, int send_pct,
                           int recv_pct, logic pressure);
    int   target;
    int   n_clicks;
    int   len;
    logic press_pin;
    write_reg(CFG_ACTIVE_LOW, CntW'(al));
    write_reg(CFG_HOLD_TIME, CntW'(ht));
    write_reg(CFG_CLICK_WINDOW, CntW'(cw));
    write_reg(CFG_MAX_CLICKS, CntW'(mc));
    write_reg(CFG_REPEAT_DIVIDER, CntW'(rd));
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    if (pressure) hold_off_asked++;
    target = samples_sent + PHASE_SAMPLES;
    while (samples_sent < target) begin
      if ($urandom_range(99) < 15) begin
        send_sample(4'($urandom_range(15)), 1'($urandom_range(1)), 1'b0, EV_NONE);
      end else begin
        logic [IdxW-1:0] btn;
        btn       = 4'($urandom_range(15));
        press_pin = ~cfg_active_low;
        n_clicks  = $urandom_range(1, 3);
        for (int c = 0; c < n_clicks; c++) begin
          if ($urandom_range(99) < 70) len = $urandom_range(1, 2);
          else len = $urandom_range(1, (cfg_hold_time < 20) ? cfg_hold_time + 8 : 12);
          repeat (len) send_sample(btn, press_pin, 1'b0, EV_NONE);
          if (c < n_clicks - 1)
            len = $urandom_range(1, (cfg_click_window > 1 && cfg_click_window < 8) ?
                                    cfg_click_window - 1 : 3);
          else
            len = $urandom_range(1, (cfg_click_window < 20) ? cfg_click_window + 3 : 8);
          repeat (len) send_sample(btn, ~press_pin, 1'b0, EV_NONE);
        end
      end
    end
  endtask

  // Receiver side: random stalls plus a long hold-off on request.
  always @(negedge clk_i) begin
    if (hold_off_asked != hold_off_seen) begin
      hold_off_seen = hold_off_asked;
      hold_off_left = LONG_HOLD_OFF;
    end
    if (hold_off_left > 0) begin
      event_ready_i <= 1'b0;
      hold_off_left--;
    end else begin
      event_ready_i <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin : event_check
    click_event_t want;
    if (rst_ni && event_valid_o && event_ready_i) begin
      events_seen++;
      case (event_code_o)
        EV_DOUBLE, EV_TRIPLE: multi_clicks_seen++;
        EV_HOLD_START:        hold_starts_seen++;
        EV_HOLD_REPEAT:       hold_repeats_seen++;
        default: ;
      endcase
      if (pending_events.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10)
          $display("unexpected event: button %0d code %0d", event_button_o, event_code_o);
      end else begin
        want = pending_events.pop_front();
        if (event_button_o !== want.button || event_code_o !== want.code) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("event mismatch: want button %0d code %0d, got button %0d code %0d",
                     want.button, want.code, event_button_o, event_code_o);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((sample_valid_i && sample_ready_o) || (event_valid_o && event_ready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
      if (stall_cycles >= WATCHDOG_LIMIT) begin
        $display("timeout after %0d cycles without a handshake", stall_cycles);
        $display("Verification failed");
        $finish;
      end
    end
  end

  initial begin
    mismatch_cnt      = 0;
    samples_sent      = 0;
    events_seen       = 0;
    multi_clicks_seen = 0;
    hold_starts_seen  = 0;
    hold_repeats_seen = 0;
    stall_cycles      = 0;
    send_idle_pct     = 0;
    recv_stall_pct    = 0;
    hold_off_asked    = 0;
    hold_off_seen     = 0;
    hold_off_left     = 0;
    reset_detector_state();

    directed_rows.push_back(sample_row(4'd0, 1'b0, 1'b1, EV_NONE));
    directed_rows.push_back(sample_row(4'd15, 1'b1, 1'b1, EV_NONE));
    directed_rows.push_back(config_row(CFG_ACTIVE_LOW, 10'd0));
    directed_rows.push_back(config_row(CFG_HOLD_TIME, 10'd3));
    directed_rows.push_back(config_row(CFG_CLICK_WINDOW, 10'd3));
    directed_rows.push_back(config_row(CFG_MAX_CLICKS, 10'd3));
    directed_rows.push_back(config_row(CFG_REPEAT_DIVIDER, 10'd2));
    // double click, then let the window run out
    directed_rows.push_back(sample_row(4'd1, 1'b1, 1'b0, EV_NONE));
    directed_rows.push_back(sample_row(4'd1, 1'b0, 1'b0, EV_NONE));
    directed_rows.push_back(sample_row(4'd1, 1'b1, 1'b0, EV_NONE));
    repeat (3) directed_rows.push_back(sample_row(4'd1, 1'b0, 1'b0, EV_NONE));
    // long press into hold start and one repeat, then release
    repeat (6) directed_rows.push_back(sample_row(4'd2, 1'b1, 1'b0, EV_NONE));
    directed_rows.push_back(sample_row(4'd2, 1'b0, 1'b0, EV_NONE));
    // zero hold time, zero click cap, zero divider
    directed_rows.push_back(config_row(CFG_HOLD_TIME, 10'd0));
    directed_rows.push_back(config_row(CFG_MAX_CLICKS, 10'd0));
    directed_rows.push_back(config_row(CFG_REPEAT_DIVIDER, 10'd0));
    directed_rows.push_back(sample_row(4'd3, 1'b1, 1'b1, EV_NONE));
    directed_rows.push_back(sample_row(4'd3, 1'b1, 1'b1, EV_HOLD_REPEAT));
    directed_rows.push_back(sample_row(4'd3, 1'b0, 1'b1, EV_NONE));

    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_CONFIG)
        write_reg(directed_rows[i].reg_sel, directed_rows[i].cfg_value);
      else
        send_sample(directed_rows[i].button, directed_rows[i].pin, directed_rows[i].typed,
                    directed_rows[i].code);
    end

    run_phase(1'b1, 1, 1, 1, 1, 0, 0, 1'b1);
    run_phase(1'b0, 5, 6, 3, 3, 49, 0, 1'b0);
    run_phase(1'b1, 1023, 1023, 2, 1023, 0, 49, 1'b0);
    run_phase(1'b0, 0, 0, 0, 0, 8, 8, 1'b0);
    run_phase(1'b0, 8, 4, 3, 2, 0, 0, 1'b0);

    @(negedge clk_i);
    sample_valid_i <= 1'b0;
    while (pending_events.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);

    $display("Sent %0d samples over five register settings, checked %0d events", samples_sent,
             events_seen);
    $display("Saw %0d multi-clicks, %0d hold starts, %0d hold repeats; %0d mismatches",
             multi_clicks_seen, hold_starts_seen, hold_repeats_seen, mismatch_cnt);
    if (mismatch_cnt == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
